/* design/assert_macros.svh */
// Assertion macros shared by the divider RTL.
// Checks are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/cid_pkg.sv */
// Types and constants for the integer divider pipeline.
// Used by every divider module; depends on nothing.
package cid_pkg;

  localparam int unsigned DividendW = 32;
  localparam int unsigned DivisorW  = 16;
  localparam int unsigned NumCells  = DividendW;

  typedef struct packed {
    logic                word;
    logic                sdiv;
    logic                qneg;
    logic                rneg;
    logic                zero;
    logic [DivisorW-1:0] zq;
    logic [DivisorW-1:0] zr;
  } ctl_t;

  typedef struct packed {
    logic [DivisorW-1:0]  rem;
    logic [DividendW-1:0] acc;
    logic [DivisorW-1:0]  dv;
    ctl_t                 ctl;
  } stage_t;

endpackage

/* design/cid_prep.sv */
// Input stage: decodes mode, takes magnitudes and the zero-divisor results.
// Depends on cid_pkg.
module cid_prep import cid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic                 cmd,
  input  logic                 word_mode,
  input  logic [DividendW-1:0] dividend,
  input  logic [DivisorW-1:0]  divisor,
  output logic                 dn_valid,
  output stage_t               dn_data,
  input  logic                 dn_ready
);

  logic [DividendW-1:0] sd;
  logic [DivisorW-1:0]  sv;
  logic                 neg_d;
  logic                 neg_v;
  stage_t               data_next;

  always_comb begin
    sd = word_mode ? dividend
                   : {{(DividendW/2){cmd & dividend[DividendW/2-1]}},
                      dividend[DividendW/2-1:0]};
    sv = word_mode ? divisor
                   : {{(DivisorW/2){cmd & divisor[DivisorW/2-1]}},
                      divisor[DivisorW/2-1:0]};
    neg_d = cmd & sd[DividendW-1];
    neg_v = cmd & sv[DivisorW-1];

    data_next.rem      = '0;
    data_next.acc      = neg_d ? (~sd + 1'b1) : sd;
    data_next.dv       = neg_v ? (~sv + 1'b1) : sv;
    data_next.ctl.word = word_mode;
    data_next.ctl.sdiv = cmd;
    data_next.ctl.qneg = neg_d ^ neg_v;
    data_next.ctl.rneg = neg_d;
    data_next.ctl.zero = (sv == '0);
    // zero divisor: complement of the upper half, lower half as remainder
    data_next.ctl.zq   = word_mode ? ~dividend[DividendW-1:DivisorW]
                                   : {8'd0, ~dividend[15:8]};
    data_next.ctl.zr   = word_mode ? dividend[DivisorW-1:0]
                                   : {8'd0, dividend[7:0]};
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

/* design/cid_cell.sv */
// One restoring-division cell: retires one quotient bit per request.
// Depends on cid_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cid_cell import cid_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   up_valid,
  output logic   up_ready,
  input  stage_t up_data,
  output logic   dn_valid,
  output stage_t dn_data,
  input  logic   dn_ready
);

  logic [DivisorW:0]   shifted;
  logic [DivisorW+1:0] diff;
  logic                ge;
  stage_t              data_next;

  always_comb begin
    shifted   = {up_data.rem, up_data.acc[DividendW-1]};
    diff      = {1'b0, shifted} - {2'b00, up_data.dv};
    ge        = !diff[DivisorW+1];
    data_next = up_data;
    // keep the difference when it did not borrow
    data_next.rem = ge ? diff[DivisorW-1:0] : shifted[DivisorW-1:0];
    data_next.acc = {up_data.acc[DividendW-2:0], ge};
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

  `ASSERT_IMPLIES(a_rem_below_dv, clk, rst, dn_valid && !dn_data.ctl.zero, dn_data.rem < dn_data.dv)

endmodule

/* design/cid_fix.sv */
// Output stage: applies signs, truncates to operand width, substitutes zero-divisor results, flags overflow.
// Depends on cid_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cid_fix import cid_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  stage_t              up_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DivisorW-1:0] quotient,
  output logic [DivisorW-1:0] remainder,
  output logic                overflow
);

  logic [DividendW-1:0] q_full;
  logic [DivisorW-1:0]  r_full;
  logic [DividendW-1:0] lim;
  logic                 ovf_u;
  logic                 ovf_s;
  logic                 sgn;
  logic [DivisorW-1:0]  q_next;
  logic [DivisorW-1:0]  r_next;
  logic                 ovf_next;
  logic                 word_q;

  always_comb begin
    q_full = up_data.ctl.qneg ? (~up_data.acc + 1'b1) : up_data.acc;
    r_full = up_data.ctl.rneg ? (~up_data.rem + 1'b1) : up_data.rem;
    // magnitude limit of a signed quotient
    lim    = up_data.ctl.word ? DividendW'(32'h8000) : DividendW'(32'h80);
    ovf_u  = up_data.ctl.word ? (|up_data.acc[DividendW-1:16])
                              : (|up_data.acc[DividendW-1:8]);
    ovf_s  = up_data.ctl.qneg ? (up_data.acc > lim) : (up_data.acc >= lim);
    // signed requests check against the signed range, even with both operands positive
    sgn    = up_data.ctl.sdiv;
    if (up_data.ctl.zero) begin
      q_next   = up_data.ctl.zq;
      r_next   = up_data.ctl.zr;
      ovf_next = 1'b1;
    end else begin
      q_next   = up_data.ctl.word ? q_full[DivisorW-1:0] : {8'd0, q_full[7:0]};
      r_next   = up_data.ctl.word ? r_full : {8'd0, r_full[7:0]};
      ovf_next = sgn ? ovf_s : ovf_u;
    end
  end

  assign up_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      quotient  <= q_next;
      remainder <= r_next;
      overflow  <= ovf_next;
      word_q    <= up_data.ctl.word;
    end
  end

  `ASSERT_NEXT(a_zero_ovf, clk, rst, up_valid && up_ready && up_data.ctl.zero, overflow)
  `ASSERT_IMPLIES(a_byte_hi, clk, rst, out_valid && !word_q, quotient[15:8] == 8'd0 && remainder[15:8] == 8'd0)

endmodule

/* design/cpu_integer_divider_unit.sv */
// Pipelined integer divider: 32/16 or 16/8, signed or unsigned.
// Request channel: in_valid/in_stall with cmd, word_mode, dividend, divisor.
// Result channel: out_valid/out_stall with quotient, remainder, overflow.
// A request is taken on an edge with valid high and stall low, on both sides.
// The path is an input stage, a chain of 32 division cells (one quotient bit
// each) and an output register; each of them is a registered stage, and a
// request moves through them in that order.
// One request can enter every cycle while out_stall stays low; throughput is
// then one result per cycle, set by the single-bit step done in each cell.
// When out_stall is held the output register keeps its result and earlier
// stages go on filling empty slots; once every stage holds a request,
// in_stall rises. Each stage moves when its successor is free or moving.
// Reset (rst, synchronous) empties every stage, dropping results in flight;
// no other is lost or made up; the block is ready the cycle after rst falls.
// Depends on cid_pkg, cid_prep, cid_cell and cid_fix.
module cpu_integer_divider_unit import cid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cmd,
  input  logic                 word_mode,
  input  logic [DividendW-1:0] dividend,
  input  logic [DivisorW-1:0]  divisor,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DivisorW-1:0]  quotient,
  output logic [DivisorW-1:0]  remainder,
  output logic                 overflow
);

  logic   vld [NumCells+1];
  logic   rdy [NumCells+1];
  stage_t dat [NumCells+1];
  logic   prep_ready;

  assign in_stall = !prep_ready;

  cid_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (in_valid),
    .up_ready  (prep_ready),
    .cmd       (cmd),
    .word_mode (word_mode),
    .dividend  (dividend),
    .divisor   (divisor),
    .dn_valid  (vld[0]),
    .dn_data   (dat[0]),
    .dn_ready  (rdy[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    cid_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (vld[i]),
      .up_ready (rdy[i]),
      .up_data  (dat[i]),
      .dn_valid (vld[i+1]),
      .dn_data  (dat[i+1]),
      .dn_ready (rdy[i+1])
    );
  end

  cid_fix u_fix (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (vld[NumCells]),
    .up_ready  (rdy[NumCells]),
    .up_data   (dat[NumCells]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .quotient  (quotient),
    .remainder (remainder),
    .overflow  (overflow)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for cpu_integer_divider_unit: directed table, then random requests.
// Depends on cid_pkg and the divider RTL; checks use known answers or a local predictor.
module testbench;
  import cid_pkg::*;

  typedef enum bit {DIV_UNSIGNED = 1'b0, DIV_SIGNED = 1'b1} div_op_e;
  typedef enum bit {MODE_BYTE = 1'b0, MODE_WORD = 1'b1} div_mode_e;

  typedef struct packed {
    logic [DivisorW-1:0] quo;
    logic [DivisorW-1:0] rem;
    logic                ovf;
  } div_result_t;

  typedef struct packed {
    div_op_e              op;
    div_mode_e            mode;
    logic [DividendW-1:0] dividend;
    logic [DivisorW-1:0]  divisor;
    bit                   typed;
    div_result_t          known;
  } div_case_t;

  localparam int unsigned NumDirected = 19;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldCycles  = 150;

  // Known answers are filled in where they are plain; the rest go to the predictor.
  localparam div_case_t DirectedCases [NumDirected] = '{
    '{DIV_UNSIGNED, MODE_BYTE, 32'h0000_0064, 16'h0007, 1'b1, '{16'h000E, 16'h0002, 1'b0}},
    '{DIV_UNSIGNED, MODE_BYTE, 32'h0000_1234, 16'h0000, 1'b1, '{16'h00ED, 16'h0034, 1'b1}},
    '{DIV_SIGNED,   MODE_WORD, 32'h8000_1234, 16'h0000, 1'b1, '{16'h7FFF, 16'h1234, 1'b1}},
    '{DIV_UNSIGNED, MODE_BYTE, 32'hFFFF_0064, 16'hFF07, 1'b1, '{16'h000E, 16'h0002, 1'b0}},
    '{DIV_UNSIGNED, MODE_BYTE, 32'hABCD_5678, 16'hFF00, 1'b1, '{16'h00A9, 16'h0078, 1'b1}},
    '{DIV_UNSIGNED, MODE_WORD, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{16'h0001, 16'h0000, 1'b1}},
    '{DIV_UNSIGNED, MODE_WORD, 32'hFFFE_0001, 16'hFFFF, 1'b1, '{16'hFFFF, 16'h0000, 1'b0}},
    '{DIV_SIGNED,   MODE_BYTE, 32'h0000_FF80, 16'h00FF, 1'b1, '{16'h0080, 16'h0000, 1'b1}},
    '{DIV_SIGNED,   MODE_WORD, 32'h8000_0000, 16'hFFFF, 1'b1, '{16'h0000, 16'h0000, 1'b1}},
    '{DIV_SIGNED,   MODE_BYTE, 32'h0000_FFF9, 16'h0002, 1'b1, '{16'h00FD, 16'h00FF, 1'b0}},
    '{DIV_SIGNED,   MODE_BYTE, 32'h0000_0007, 16'h00FE, 1'b1, '{16'h00FD, 16'h0001, 1'b0}},
    '{DIV_SIGNED,   MODE_WORD, 32'hFFFF_8000, 16'h0001, 1'b1, '{16'h8000, 16'h0000, 1'b0}},
    '{DIV_SIGNED,   MODE_WORD, 32'h0000_8000, 16'h0001, 1'b1, '{16'h8000, 16'h0000, 1'b1}},
    '{DIV_SIGNED,   MODE_BYTE, 32'h0000_80FF, 16'h0000, 1'b1, '{16'h007F, 16'h00FF, 1'b1}},
    '{DIV_UNSIGNED, MODE_BYTE, 32'h0000_FFFF, 16'h00FF, 1'b1, '{16'h0001, 16'h0000, 1'b1}},
    '{DIV_UNSIGNED, MODE_BYTE, 32'h0000_0000, 16'h0001, 1'b1, '{16'h0000, 16'h0000, 1'b0}},
    '{DIV_SIGNED,   MODE_WORD, 32'hFFFF_FFFF, 16'h8000, 1'b1, '{16'h0000, 16'hFFFF, 1'b0}},
    '{DIV_SIGNED,   MODE_BYTE, 32'h1234_FFF9, 16'hAB02, 1'b1, '{16'h00FD, 16'h00FF, 1'b0}},
    '{DIV_SIGNED,   MODE_WORD, 32'h7FFF_FFFF, 16'h7FFF, 1'b0, '{16'h0000, 16'h0000, 1'b0}}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 cmd = 1'b0;
  logic                 word_mode = 1'b0;
  logic [DividendW-1:0] dividend = '0;
  logic [DivisorW-1:0]  divisor = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DivisorW-1:0]  quotient;
  logic [DivisorW-1:0]  remainder;
  logic                 overflow;

  div_result_t pending_results[$];
  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 68;
  logic        long_hold = 1'b0;
  int unsigned accepted_count = 0;
  int unsigned overflow_count = 0;
  int unsigned zero_div_count = 0;
  int unsigned checked_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  cpu_integer_divider_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .word_mode (word_mode),
    .dividend  (dividend),
    .divisor   (divisor),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .quotient  (quotient),
    .remainder (remainder),
    .overflow  (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic div_result_t predict_division(div_op_e op, div_mode_e mode,
                                                   logic [DividendW-1:0] dd_in,
                                                   logic [DivisorW-1:0] dv_in);
    int unsigned     n;
    longint unsigned nmask, dd, dv, uq;
    longint          sd, sv, sq, sr, lim;
    div_result_t     res;
    n     = (mode == MODE_WORD) ? 16 : 8;
    nmask = (64'd1 << n) - 1;
    dd    = dd_in & ((64'd1 << (2 * n)) - 1);
    dv    = dv_in & nmask;
    if (dv == 0) begin
      res.quo = 16'(~(dd >> n) & nmask);
      res.rem = 16'(dd & nmask);
      res.ovf = 1'b1;
    end else if (op == DIV_UNSIGNED) begin
      uq      = dd / dv;
      res.quo = 16'(uq & nmask);
      res.rem = 16'(dd % dv);
      res.ovf = uq > nmask;
    end else begin
      sd = dd;
      if (dd[2*n-1]) sd = sd - (longint'(1) << (2 * n));
      sv = dv;
      if (dv[n-1]) sv = sv - (longint'(1) << n);
      sq      = sd / sv;
      sr      = sd % sv;
      lim     = longint'(1) << (n - 1);
      res.quo = 16'(sq) & 16'(nmask);
      res.rem = 16'(sr) & 16'(nmask);
      res.ovf = (sq < -lim) || (sq > lim - 1);
    end
    return res;
  endfunction

  // Mostly exact q*d+r constructions, so quotients land in range, at its edges and past them.
  task automatic make_random_case(output div_case_t c);
    int unsigned     n, pick;
    longint unsigned nmask, half, mag_d, mag_q, mag_r, qlim, dd, dv;
    bit              neg_d, neg_x, constructed;
    c           = '0;
    c.op        = div_op_e'($urandom_range(0, 1));
    c.mode      = div_mode_e'($urandom_range(0, 1));
    c.dividend  = $urandom;
    c.divisor   = 16'($urandom);
    n           = (c.mode == MODE_WORD) ? 16 : 8;
    nmask       = (64'd1 << n) - 1;
    half        = 64'd1 << (n - 1);
    pick        = $urandom_range(0, 99);
    constructed = 1'b0;
    neg_d       = 1'b0;
    neg_x       = 1'b0;
    dd          = 0;
    dv          = 0;
    if (pick < 60) begin
      if (c.op == DIV_UNSIGNED) begin
        mag_d = $urandom_range(1, 32'(nmask));
        qlim  = nmask;
      end else begin
        neg_d = $urandom_range(0, 1);
        neg_x = $urandom_range(0, 1);
        mag_d = $urandom_range(1, 32'(neg_d ? half : half - 1));
        qlim  = (neg_d ^ neg_x) ? half : half - 1;
      end
      mag_d = mag_d >> $urandom_range(0, n - 1);
      if (mag_d == 0) mag_d = 1;
      if ($urandom_range(0, 3) == 0) begin
        mag_q = qlim + $urandom_range(0, 1);
      end else begin
        mag_q = $urandom_range(0, 32'(qlim));
        mag_q = mag_q >> $urandom_range(0, n - 1);
      end
      mag_r       = $urandom_range(0, 32'(mag_d - 1));
      dd          = mag_q * mag_d + mag_r;
      dv          = mag_d;
      constructed = 1'b1;
    end else if (pick < 75) begin
      // leave fully random operands
    end else if (pick < 85) begin
      if (c.mode == MODE_WORD) c.divisor = '0;
      else c.divisor[7:0] = '0;
    end else begin
      dd          = $urandom_range(0, 255);
      dv          = $urandom_range(1, 15);
      neg_x       = $urandom_range(0, 1);
      neg_d       = $urandom_range(0, 1);
      constructed = 1'b1;
    end
    if (constructed) begin
      if (neg_x) dd = -dd;
      if (neg_d) dv = -dv;
      if (c.mode == MODE_WORD) begin
        c.dividend = 32'(dd);
        c.divisor  = 16'(dv);
      end else begin
        c.dividend[15:0] = 16'(dd);
        c.divisor[7:0]   = 8'(dv);
      end
    end
  endtask

  task automatic send_request(input div_case_t c);
    div_result_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c.op;
    word_mode <= c.mode;
    dividend  <= c.dividend;
    divisor   <= c.divisor;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = c.typed ? c.known : predict_division(c.op, c.mode, c.dividend, c.divisor);
    pending_results.push_back(want);
    accepted_count++;
    if (want.ovf) overflow_count++;
    if ((c.mode == MODE_WORD) ? (c.divisor == '0) : (c.divisor[7:0] == '0)) zero_div_count++;
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch %0d at cycle %0d: %s", mismatch_count,
                                       cycle_count, what);
  endtask

  task automatic check_result();
    div_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result q=%h r=%h ovf=%b with no request pending",
                                quotient, remainder, overflow));
    end else begin
      want = pending_results.pop_front();
      checked_count++;
      if (quotient !== want.quo)
        report_mismatch($sformatf("quotient %h, want %h", quotient, want.quo));
      if (remainder !== want.rem)
        report_mismatch($sformatf("remainder %h, want %h", remainder, want.rem));
      if (overflow !== want.ovf)
        report_mismatch($sformatf("overflow %b, want %b", overflow, want.ovf));
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("[cpu_integer_divider_unit] ERROR");
      $finish;
    end
  end

  // Result side: check on acceptance, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) check_result();
      if (long_hold) out_stall <= 1'b1;
      else out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Hold the result side off long enough for the pipeline to fill and back up.
  initial begin
    wait (accepted_count >= NumDirected + 1300);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    div_case_t c;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < NumDirected; i++) send_request(DirectedCases[i]);
    for (int i = 0; i < 600; i++) begin
      make_random_case(c);
      send_request(c);
    end
    send_idle_pct <= 68;
    recv_idle_pct <= 29;
    for (int i = 0; i < 600; i++) begin
      make_random_case(c);
      send_request(c);
    end
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    for (int i = 0; i < 500; i++) begin
      make_random_case(c);
      send_request(c);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("%0d divisions checked (%0d from the directed table) in %0d cycles",
             checked_count, NumDirected, cycle_count);
    $display("%0d overflowed, %0d by a zero divisor, %0d mismatches",
             overflow_count, zero_div_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[cpu_integer_divider_unit] OK");
    end else begin
      $display("[cpu_integer_divider_unit] ERROR");
    end
    $finish;
  end

endmodule
